[hw/rtl/rccpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rccpg_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAME_BYTES = 16;
    localparam int AXIS_BITS   = 12;

    localparam logic [SAMPLE_BITS-1:0] STICK_CENTER = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [AXIS_BITS-1:0]   AXIS_BASE    = AXIS_BITS'(1250);
    localparam logic [AXIS_BITS-1:0]   THR_BASE     = AXIS_BITS'(1000);
    localparam logic [3:0]             LAST_INDEX   = 4'(FRAME_BYTES - 1);
    localparam logic [3:0]             SPEED_MAX    = 4'd15;
    localparam logic [3:0]             SPEED_CUT    = 4'd3;

    localparam logic [7:0] HDR_0     = 8'h24;
    localparam logic [7:0] HDR_1     = 8'h4D;
    localparam logic [7:0] HDR_2     = 8'h3C;
    localparam logic [7:0] MSG_SIZE  = 8'h0A;
    localparam logic [7:0] MSG_TYPE  = 8'hC8;
    localparam logic [7:0] YAW_LO    = 8'hDC;
    localparam logic [7:0] YAW_HI    = 8'h05;
    localparam logic [7:0] ARM_ON_LO = 8'hD0;
    localparam logic [7:0] ARM_ON_HI = 8'h07;
    localparam logic [7:0] ARM_OFF_LO = 8'hE8;
    localparam logic [7:0] ARM_OFF_HI = 8'h03;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_STICK = 3'd1,
        OP_PAD   = 3'd2,
        OP_ARM   = 3'd3,
        OP_SEND  = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_DEADBAND    = 3'd0,
        CFG_PAD_HOLDOFF = 3'd1,
        CFG_ARM_HOLDOFF = 3'd2,
        CFG_THR_STEP    = 3'd3,
        CFG_LINK_READY  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]             opcode;
        logic [SAMPLE_BITS-1:0] stick_x;
        logic [SAMPLE_BITS-1:0] stick_y;
        logic                   button_up;
        logic                   button_down;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [3:0] byte_index;
        logic       has_frame;
        logic       last;
        logic [3:0] leds;
    } out_beat_t;

    typedef struct packed {
        logic                 has_frame;
        logic                 armed;
        logic [AXIS_BITS-1:0] pitch;
        logic [AXIS_BITS-1:0] roll;
        logic [AXIS_BITS-1:0] thr;
        logic [3:0]           leds;
    } frame_desc_t;

    function automatic logic [7:0] frame_byte_at(frame_desc_t d, logic [3:0] idx,
                                                 logic [7:0] chk);
        logic [7:0] b;
        case (idx)
            4'd0:    b = HDR_0;
            4'd1:    b = HDR_1;
            4'd2:    b = HDR_2;
            4'd3:    b = MSG_SIZE;
            4'd4:    b = MSG_TYPE;
            4'd5:    b = d.pitch[7:0];
            4'd6:    b = 8'(d.pitch[AXIS_BITS-1:8]);
            4'd7:    b = d.roll[7:0];
            4'd8:    b = 8'(d.roll[AXIS_BITS-1:8]);
            4'd9:    b = d.thr[7:0];
            4'd10:   b = 8'(d.thr[AXIS_BITS-1:8]);
            4'd11:   b = YAW_LO;
            4'd12:   b = YAW_HI;
            4'd13:   b = d.armed ? ARM_ON_LO : ARM_OFF_LO;
            4'd14:   b = d.armed ? ARM_ON_HI : ARM_OFF_HI;
            default: b = chk;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] frame_checksum(frame_desc_t d);
        logic [7:0] x;
        x = 8'h00;
        for (int i = 3; i < FRAME_BYTES - 1; i++) begin
            x = x ^ frame_byte_at(d, 4'(i), 8'h00);
        end
        return x;
    endfunction

    function automatic logic [3:0] chase_leds(logic [2:0] c);
        logic [3:0] l;
        l[0] = (c == 3'd3) || (c == 3'd4);
        l[1] = (c == 3'd2) || (c == 3'd5);
        l[2] = (c == 3'd1) || (c == 3'd6);
        l[3] = (c == 3'd0) || (c == 3'd7);
        return l;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rccpg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rccpg_ctrl
    import rccpg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        item_take,
    input  wire in_beat_t    item,
    output frame_desc_t      desc
);

    logic [11:0]            deadband_reg;
    logic [15:0]            pad_holdoff_reg;
    logic [15:0]            arm_holdoff_reg;
    logic [6:0]             thr_step_reg;
    logic                   link_ready_reg;

    logic [31:0]            tick_count_reg, tick_count_next;
    logic [31:0]            pad_last_reg, pad_last_next;
    logic [31:0]            arm_last_reg, arm_last_next;
    logic [SAMPLE_BITS-1:0] held_x_reg, held_x_next;
    logic [SAMPLE_BITS-1:0] held_y_reg, held_y_next;
    logic                   up_pend_reg, up_pend_next;
    logic                   down_pend_reg, down_pend_next;
    logic [3:0]             speed_reg, speed_next;
    logic                   armed_reg, armed_next;
    logic [2:0]             phase_reg, phase_next;

    logic [SAMPLE_BITS-1:0] diff_x, diff_y;
    logic                   pad_ok, arm_ok;
    logic [3:0]             speed_step;
    logic [2:0]             phase_inc;
    logic [AXIS_BITS-1:0]   thr_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg    <= 12'd40;
            pad_holdoff_reg <= 16'd180;
            arm_holdoff_reg <= 16'd250;
            thr_step_reg    <= 7'd65;
            link_ready_reg  <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_DEADBAND:    deadband_reg    <= cfg_data[11:0];
                CFG_PAD_HOLDOFF: pad_holdoff_reg <= cfg_data;
                CFG_ARM_HOLDOFF: arm_holdoff_reg <= cfg_data;
                CFG_THR_STEP:    thr_step_reg    <= cfg_data[6:0];
                CFG_LINK_READY:  link_ready_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign diff_x = (item.stick_x > held_x_reg) ? item.stick_x - held_x_reg
                                                : held_x_reg - item.stick_x;
    assign diff_y = (item.stick_y > held_y_reg) ? item.stick_y - held_y_reg
                                                : held_y_reg - item.stick_y;
    assign pad_ok = (tick_count_reg - pad_last_reg) > {16'd0, pad_holdoff_reg};
    assign arm_ok = (tick_count_reg - arm_last_reg) > {16'd0, arm_holdoff_reg};
    assign phase_inc = phase_reg + 3'd1;

    always_comb begin
        case ({up_pend_reg, down_pend_reg})
            2'b10:   speed_step = (speed_reg == SPEED_MAX) ? speed_reg : speed_reg + 4'd1;
            2'b01:   speed_step = (speed_reg == 4'd0) ? speed_reg : speed_reg - 4'd1;
            default: speed_step = speed_reg;
        endcase
    end

    assign thr_prod = AXIS_BITS'(speed_step * thr_step_reg);

    always_comb begin
        tick_count_next = tick_count_reg;
        pad_last_next   = pad_last_reg;
        arm_last_next   = arm_last_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        up_pend_next    = up_pend_reg;
        down_pend_next  = down_pend_reg;
        speed_next      = speed_reg;
        armed_next      = armed_reg;
        phase_next      = phase_reg;
        if (item_take) begin
            case (item.opcode)
                OP_TICK: begin
                    tick_count_next = tick_count_reg + 32'd1;
                end
                OP_STICK: begin
                    if (diff_x > deadband_reg) held_x_next = item.stick_x;
                    if (diff_y > deadband_reg) held_y_next = item.stick_y;
                end
                OP_PAD: begin
                    if (pad_ok) begin
                        pad_last_next  = tick_count_reg;
                        up_pend_next   = item.button_up;
                        down_pend_next = item.button_down;
                    end
                end
                OP_ARM: begin
                    if (arm_ok) begin
                        arm_last_next = tick_count_reg;
                        armed_next    = !armed_reg;
                        if (speed_reg >= SPEED_CUT) speed_next = 4'd0;
                    end
                end
                OP_SEND: begin
                    phase_next = phase_inc;
                    if (link_ready_reg) begin
                        speed_next     = speed_step;
                        up_pend_next   = 1'b0;
                        down_pend_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= 32'd0;
            pad_last_reg   <= 32'd0;
            arm_last_reg   <= 32'd0;
            held_x_reg     <= STICK_CENTER;
            held_y_reg     <= STICK_CENTER;
            up_pend_reg    <= 1'b0;
            down_pend_reg  <= 1'b0;
            speed_reg      <= 4'd0;
            armed_reg      <= 1'b1;
            phase_reg      <= 3'd0;
        end else begin
            tick_count_reg <= tick_count_next;
            pad_last_reg   <= pad_last_next;
            arm_last_reg   <= arm_last_next;
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            up_pend_reg    <= up_pend_next;
            down_pend_reg  <= down_pend_next;
            speed_reg      <= speed_next;
            armed_reg      <= armed_next;
            phase_reg      <= phase_next;
        end
    end

    always_comb begin
        desc.has_frame = link_ready_reg;
        desc.armed     = armed_reg;
        desc.pitch     = AXIS_BITS'(held_x_reg[SAMPLE_BITS-1 -: 9]) + AXIS_BASE;
        desc.roll      = AXIS_BITS'(held_y_reg[SAMPLE_BITS-1 -: 9]) + AXIS_BASE;
        desc.thr       = thr_prod + THR_BASE;
        if (!link_ready_reg) begin
            desc.leds = chase_leds(phase_inc);
        end else if (armed_reg) begin
            desc.leds = speed_step;
        end else begin
            desc.leds = (phase_inc == 3'd1) ? 4'd5 : ((phase_inc == 3'd0) ? 4'd10 : 4'd0);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rccpg_serializer.sv]
`timescale 1ns / 1ps
`default_nettype none

module rccpg_serializer
    import rccpg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        desc_valid,
    output logic             desc_ready,
    input  wire frame_desc_t desc,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data
);

    logic        busy_reg;
    logic [3:0]  idx_reg;
    frame_desc_t snap_reg;
    logic [7:0]  chk_reg;
    out_beat_t   out_reg;
    logic        out_valid_reg;

    logic        advance;
    logic        cur_last;
    logic        emit;
    out_beat_t   beat;

    assign advance    = !out_valid_reg || m_ready;
    assign cur_last   = !snap_reg.has_frame || (idx_reg == LAST_INDEX);
    assign emit       = busy_reg && advance;
    assign desc_ready = !busy_reg || (advance && cur_last);

    always_comb begin
        beat.frame_byte = snap_reg.has_frame ? frame_byte_at(snap_reg, idx_reg, chk_reg) : 8'h00;
        beat.byte_index = idx_reg;
        beat.has_frame  = snap_reg.has_frame;
        beat.last       = cur_last;
        beat.leds       = snap_reg.leds;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (desc_valid && desc_ready) begin
                busy_reg <= 1'b1;
                idx_reg  <= 4'd0;
            end else if (emit) begin
                idx_reg <= idx_reg + 4'd1;
                if (cur_last) busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) out_reg <= beat;
        if (desc_valid && desc_ready) begin
            snap_reg <= desc;
            chk_reg  <= frame_checksum(desc);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

[hw/rtl/rc_command_packet_generator_core.sv]
// Command frame generator for a joystick remote.
// Input channel (s_valid/s_ready/s_data): one event per beat - tick, stick
// sample, pad buttons, stick button or send period. Events other than send
// are absorbed in the cycle they are accepted and give no output.
// Output channel (m_valid/m_ready/m_data): a send with the link up gives
// sixteen beats, one frame byte each, byte_index 0..15, last on byte 15;
// a send with the link down gives one light-only beat with last set.
// A send loads a frame snapshot; the serializer then registers each byte
// into the output beat. Throughput: one output beat per cycle while the
// receiver takes beats. A following send is accepted at the edge that loads
// the previous frame's last byte, non-send events at any time.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write only while no frame is in flight.
// Reset (aresetn low, synchronous) restores register defaults, centers the
// held stick, sets armed, clears speed, counters and the output valid.
// When the receiver stalls, the output beat holds and the serializer stops;
// once a send is waiting behind the current frame, s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module rc_command_packet_generator_core
    import rccpg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_beat_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_beat_t        m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    frame_desc_t desc;
    logic        is_send;
    logic        desc_ready;

    assign cfg_ready = 1'b1;
    assign is_send   = (s_data.opcode == OP_SEND);
    assign s_ready   = !is_send || desc_ready;

    rccpg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_take (s_valid && s_ready),
        .item      (s_data),
        .desc      (desc)
    );

    rccpg_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (s_valid && is_send),
        .desc_ready (desc_ready),
        .desc       (desc),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

[hw/rtl/rccpg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rccpg_checker
    import rccpg_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_beat_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");

    a_light_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_frame |-> m_data.last && (m_data.byte_index == 4'd0)
            && (m_data.frame_byte == 8'h00))
        else $error("light-only beat malformed");

    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.has_frame |-> m_data.last == (m_data.byte_index == LAST_INDEX))
        else $error("last flag not on final frame byte");

    a_frame_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> m_valid && m_data.has_frame
            && (m_data.byte_index == 4'($past(m_data.byte_index) + 4'd1)))
        else $error("frame bytes not contiguous");

    a_frame_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> m_data.leds == $past(m_data.leds))
        else $error("lights changed inside a frame");

endmodule

bind rc_command_packet_generator_core rccpg_checker u_rccpg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[tb/sv/rccpg_frame_checker.sv]
`timescale 1ns / 1ps

module rccpg_frame_checker
    import rccpg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_beat_t    s_data,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_beat_t   m_data,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output int               mismatches,
    output int               beats_owed,
    output int               frame_beats,
    output int               chase_beats
);

    logic [11:0]            deadband;
    logic [15:0]            pad_holdoff;
    logic [15:0]            arm_holdoff;
    logic [6:0]             thr_step;
    logic                   link_up;

    logic [31:0]            ticks;
    logic [31:0]            pad_mark;
    logic [31:0]            arm_mark;
    logic [SAMPLE_BITS-1:0] pos_x;
    logic [SAMPLE_BITS-1:0] pos_y;
    logic                   want_up;
    logic                   want_down;
    logic [3:0]             speed;
    logic                   armed;
    logic [2:0]             phase;

    out_beat_t              owed_q[$];
    int                     n_err;
    int                     n_frame;
    int                     n_chase;

    function automatic logic [SAMPLE_BITS-1:0] follow_axis(logic [SAMPLE_BITS-1:0] held,
                                                           logic [SAMPLE_BITS-1:0] sample);
        logic [SAMPLE_BITS-1:0] gap;
        gap = (sample > held) ? sample - held : held - sample;
        return (gap > deadband) ? sample : held;
    endfunction

    function automatic logic [15:0] axis_word(logic [SAMPLE_BITS-1:0] held);
        return 16'(held >> (SAMPLE_BITS - 9)) + 16'd1250;
    endfunction

    task automatic queue_send();
        logic [7:0]  frame [FRAME_BYTES];
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [15:0] thr;
        logic [7:0]  sum;
        logic [3:0]  lights;
        int          lvl;
        int          i;
        out_beat_t   b;
        phase = phase + 3'd1;
        if (!link_up) begin
            case (phase)
                3'd0, 3'd7: lights = 4'b1000;
                3'd1, 3'd6: lights = 4'b0100;
                3'd2, 3'd5: lights = 4'b0010;
                default:    lights = 4'b0001;
            endcase
            b.frame_byte = 8'h00;
            b.byte_index = 4'd0;
            b.has_frame  = 1'b0;
            b.last       = 1'b1;
            b.leds       = lights;
            owed_q.push_back(b);
        end else begin
            lvl = int'(speed) + int'(want_up) - int'(want_down);
            if (lvl < 0) lvl = 0;
            if (lvl > 15) lvl = 15;
            speed     = 4'(lvl);
            want_up   = 1'b0;
            want_down = 1'b0;

            pitch = axis_word(pos_x);
            roll  = axis_word(pos_y);
            thr   = 16'(speed) * 16'(thr_step) + 16'd1000;

            frame[0]  = 8'h24;
            frame[1]  = 8'h4D;
            frame[2]  = 8'h3C;
            frame[3]  = 8'h0A;
            frame[4]  = 8'hC8;
            frame[5]  = pitch[7:0];
            frame[6]  = pitch[15:8];
            frame[7]  = roll[7:0];
            frame[8]  = roll[15:8];
            frame[9]  = thr[7:0];
            frame[10] = thr[15:8];
            frame[11] = 8'hDC;
            frame[12] = 8'h05;
            frame[13] = armed ? 8'hD0 : 8'hE8;
            frame[14] = armed ? 8'h07 : 8'h03;
            sum = 8'h00;
            for (i = 3; i < FRAME_BYTES - 1; i++) sum = sum ^ frame[i];
            frame[FRAME_BYTES-1] = sum;

            if (armed) lights = speed;
            else if (phase == 3'd1) lights = 4'b0101;
            else if (phase == 3'd0) lights = 4'b1010;
            else lights = 4'b0000;

            for (i = 0; i < FRAME_BYTES; i++) begin
                b.frame_byte = frame[i];
                b.byte_index = 4'(i);
                b.has_frame  = 1'b1;
                b.last       = (i == FRAME_BYTES - 1);
                b.leds       = lights;
                owed_q.push_back(b);
            end
        end
    endtask

    task automatic take_event(in_beat_t ev);
        case (ev.opcode)
            OP_TICK: ticks = ticks + 32'd1;
            OP_STICK: begin
                pos_x = follow_axis(pos_x, ev.stick_x);
                pos_y = follow_axis(pos_y, ev.stick_y);
            end
            OP_PAD: begin
                if ((ticks - pad_mark) > {16'd0, pad_holdoff}) begin
                    pad_mark  = ticks;
                    want_up   = ev.button_up;
                    want_down = ev.button_down;
                end
            end
            OP_ARM: begin
                if ((ticks - arm_mark) > {16'd0, arm_holdoff}) begin
                    arm_mark = ticks;
                    armed    = ~armed;
                    if (speed >= 4'd3) speed = 4'd0;
                end
            end
            OP_SEND: queue_send();
            default: ;
        endcase
    endtask

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got,
                                 logic [3:0] idx);
        if (want !== got) begin
            n_err++;
            $display("%0t: %s mismatch at byte %0d: expected %0h, actual %0h",
                     $time, name, idx, want, got);
        end
    endtask

    task automatic check_beat(out_beat_t got);
        out_beat_t want;
        if (owed_q.size() == 0) begin
            n_err++;
            $display("%0t: output beat with nothing expected: expected none, actual %h",
                     $time, got);
        end else begin
            want = owed_q.pop_front();
            compare_field("frame_byte", want.frame_byte, got.frame_byte, want.byte_index);
            compare_field("byte_index", 8'(want.byte_index), 8'(got.byte_index),
                          want.byte_index);
            compare_field("has_frame", 8'(want.has_frame), 8'(got.has_frame),
                          want.byte_index);
            compare_field("last", 8'(want.last), 8'(got.last), want.byte_index);
            compare_field("leds", 8'(want.leds), 8'(got.leds), want.byte_index);
            if (want.has_frame) n_frame++;
            else n_chase++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            deadband    = 12'd40;
            pad_holdoff = 16'd180;
            arm_holdoff = 16'd250;
            thr_step    = 7'd65;
            link_up     = 1'b0;
            ticks       = '0;
            pad_mark    = '0;
            arm_mark    = '0;
            pos_x       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            pos_y       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            want_up     = 1'b0;
            want_down   = 1'b0;
            speed       = '0;
            armed       = 1'b1;
            phase       = '0;
            n_err       = 0;
            n_frame     = 0;
            n_chase     = 0;
            owed_q.delete();
        end else begin
            if (s_valid && s_ready) take_event(s_data);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEADBAND:    deadband    = cfg_data[11:0];
                    CFG_PAD_HOLDOFF: pad_holdoff = cfg_data;
                    CFG_ARM_HOLDOFF: arm_holdoff = cfg_data;
                    CFG_THR_STEP:    thr_step    = cfg_data[6:0];
                    CFG_LINK_READY:  link_up     = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) check_beat(m_data);
        end
        mismatches  <= n_err;
        beats_owed  <= owed_q.size();
        frame_beats <= n_frame;
        chase_beats <= n_chase;
    end

endmodule

[tb/sv/tb_rc_command_packet_generator_core.sv]
`timescale 1ns / 1ps

module tb_rc_command_packet_generator_core;
    import rccpg_pkg::*;

    localparam int          HALF_PERIOD   = 5;
    localparam int          RESET_CYCLES  = 6;
    localparam int          MAX_GAP       = 4;
    localparam int          SETTLE        = 4;
    localparam int          LONG_HOLD     = 60;
    localparam int          STALL_LIMIT   = 1000;
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_ITEMS   = 14;
    localparam int          OP_SPACE      = 8;
    localparam logic [11:0] DEADBAND_MAX  = 12'hFFF;
    localparam logic [15:0] HOLDOFF_MAX   = 16'hFFFF;
    localparam int          THR_STEP_MAX  = 66;
    localparam int          SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int          SAMPLE_MID    = 1 << (SAMPLE_BITS - 1);

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_beat_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_beat_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int mismatches;
    int beats_owed;
    int frame_beats;
    int chase_beats;
    int events_sent   = 0;
    int settings_used = 0;
    int holds_asked   = 0;
    int holds_done    = 0;
    bit steady        = 1'b0;
    bit climb         = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    rc_command_packet_generator_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rccpg_frame_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .beats_owed  (beats_owed),
        .frame_beats (frame_beats),
        .chase_beats (chase_beats)
    );

    task automatic offer(logic [2:0] op, logic [SAMPLE_BITS-1:0] x,
                         logic [SAMPLE_BITS-1:0] y, logic up, logic down);
        in_beat_t ev;
        int       gap;
        ev.opcode      = op;
        ev.stick_x     = x;
        ev.stick_y     = y;
        ev.button_up   = up;
        ev.button_down = down;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        events_sent++;
    endtask

    task automatic offer_op(logic [2:0] op);
        offer(op, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
              SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [SAMPLE_BITS-1:0] stick_sample();
        logic [SAMPLE_BITS-1:0] s;
        case ($urandom_range(0, 3))
            0: s = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
            1: s = SAMPLE_BITS'(SAMPLE_MID - 64 + $urandom_range(0, 128));
            default: s = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        endcase
        return s;
    endfunction

    function automatic logic [15:0] pick_holdoff();
        logic [15:0] h;
        if (climb) h = 16'($urandom_range(0, 2));
        else begin
            case ($urandom_range(0, 3))
                0: h = 16'd0;
                1: h = HOLDOFF_MAX;
                2: h = 16'($urandom_range(1, 6));
                default: h = 16'($urandom_range(0, 40));
            endcase
        end
        return h;
    endfunction

    task automatic set_regs(logic [11:0] dead, logic [15:0] pad_hold,
                            logic [15:0] arm_hold, logic [6:0] step, logic link);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEADBAND;
        cfg_data  <= 16'(dead);
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_PAD_HOLDOFF;
        cfg_data  <= pad_hold;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_ARM_HOLDOFF;
        cfg_data  <= arm_hold;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_THR_STEP;
        cfg_data  <= 16'(step);
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_LINK_READY;
        cfg_data  <= 16'(link);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (beats_owed != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // one control loop pass: ticks, buttons, stick, arm toggle, then a send
    task automatic control_pass();
        logic up;
        logic down;
        repeat ($urandom_range(1, 3)) offer_op(OP_TICK);
        if ($urandom_range(0, 3) != 0) begin
            if (climb) begin
                up   = ($urandom_range(0, 9) != 0);
                down = ($urandom_range(0, 9) == 0);
            end else begin
                up   = 1'($urandom_range(0, 1));
                down = 1'($urandom_range(0, 1));
            end
            offer(OP_PAD, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                  SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)), up, down);
        end
        if ($urandom_range(0, 2) == 0)
            offer(OP_STICK, stick_sample(), stick_sample(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if (!climb && $urandom_range(0, 4) == 0) offer_op(OP_ARM);
        offer_op(OP_SEND);
    endtask

    initial begin : sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (holds_done != holds_asked) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int          k;
        int          op;
        int          phase_start;
        logic [11:0] dead;
        logic [6:0]  step;
        logic        link;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // link down: light chase only, spare opcodes, presses inside default hold-off
        offer_op(OP_SEND);
        offer_op(OP_SEND);
        for (op = int'(OP_SEND) + 1; op < OP_SPACE; op++) offer_op(3'(op));
        offer(OP_PAD, '0, '0, 1'b1, 1'b1);
        offer_op(OP_ARM);
        offer_op(OP_TICK);
        offer(OP_STICK, '0, SAMPLE_BITS'(SAMPLE_MAX), 1'b0, 1'b0);
        offer_op(OP_SEND);
        drain();

        set_regs(DEADBAND_MAX, 16'd0, 16'd0, 7'd0, 1'b1);
        offer_op(OP_SEND);
        // change smaller than the deadband is held off
        offer(OP_STICK, SAMPLE_BITS'(SAMPLE_MAX), '0, 1'b1, 1'b1);
        offer_op(OP_TICK);
        offer(OP_PAD, '0, '0, 1'b1, 1'b0);
        offer_op(OP_SEND);
        offer_op(OP_TICK);
        offer_op(OP_ARM);
        offer_op(OP_SEND);
        offer_op(OP_TICK);
        offer(OP_PAD, '0, '0, 1'b0, 1'b1);
        offer_op(OP_SEND);
        offer_op(OP_TICK);
        offer(OP_PAD, '0, '0, 1'b0, 1'b1);
        offer_op(OP_SEND);

        for (k = 0; k < RANDOM_PHASES; k++) begin
            drain();
            climb  = (k < 3);
            steady = (k == 1 || k == 4);
            case ($urandom_range(0, 3))
                0: dead = 12'd0;
                1: dead = DEADBAND_MAX;
                2: dead = 12'd40;
                default: dead = 12'($urandom_range(0, int'(DEADBAND_MAX)));
            endcase
            case ($urandom_range(0, 2))
                0: step = 7'd0;
                1: step = 7'(THR_STEP_MAX);
                default: step = 7'($urandom_range(0, THR_STEP_MAX));
            endcase
            link = (k == 3) || (k == 5) || ($urandom_range(0, 4) != 0);
            set_regs(dead, pick_holdoff(), pick_holdoff(), step, link);

            if (k == 3) begin
                // output held off while sends keep coming
                holds_asked++;
                repeat (5) offer_op(OP_SEND);
            end

            phase_start = events_sent;
            while (events_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 8) control_pass();
                else offer_op(3'($urandom_range(0, OP_SPACE - 1)));
            end
        end
        drain();

        $display("Covered %0d events, %0d frames and %0d light-only beats",
                 events_sent, frame_beats / FRAME_BYTES, chase_beats);
        $display("under %0d register settings, with one long output stall", settings_used);
        if (mismatches == 0 && beats_owed == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
